// ----- design/atr_interface_byte_parser_top_defines.svh -----
// Assertion macros shared by the ATR parser checker.
`ifndef ATR_INTERFACE_BYTE_PARSER_TOP_DEFINES_SVH
`define ATR_INTERFACE_BYTE_PARSER_TOP_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ATR_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ATR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/atr_pkg.sv -----
// Types and constants of the ATR interface byte parser.
package atr_pkg;

  typedef enum logic [1:0] {
    PH_TS   = 2'd0,
    PH_T0   = 2'd1,
    PH_IF   = 2'd2,
    PH_SKIP = 2'd3
  } atr_phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_TS = 2'd1,
    ST_TRUNC  = 2'd2
  } atr_status_e;

  // Convention bytes for direct and inverse convention.
  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  // Protocol number in a TD low nibble that marks the eUICC group.
  localparam logic [3:0] PROTO_T15 = 4'hF;

  // Presence bit positions inside one interface group.
  localparam int unsigned PB_TA = 0;
  localparam int unsigned PB_TB = 1;
  localparam int unsigned PB_TC = 2;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    atr_phase_e  phase;
    logic [3:0]  pending;   // presence bits still owed: TA, TB, TC, TD
    logic [3:0]  td_proto;  // protocol nibble of the most recent TD
    logic        euicc;
    logic        bad_ts;
  } atr_state_t;

  typedef struct packed {
    atr_status_e status;
    logic        euicc;
  } atr_result_t;

  localparam atr_state_t ATR_STATE_RST = '{
    phase:    PH_TS,
    pending:  4'h0,
    td_proto: 4'h0,
    euicc:    1'b0,
    bad_ts:   1'b0
  };

endpackage

// ----- design/atr_ifs.sv -----
// Valid/ready channel interfaces for ATR bytes in and parse results out.
interface atr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface atr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       euicc_available;

  modport source (output valid, output status, output euicc_available, input ready);
  modport sink   (input valid, input status, input euicc_available, output ready);
endinterface

// ----- design/atr_step.sv -----
// Per-byte next-state and result logic of the ATR parser.
module atr_step (
  input  atr_pkg::atr_state_t  state_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output atr_pkg::atr_state_t  state_o,
  output atr_pkg::atr_result_t result_o
);
  import atr_pkg::*;

  atr_state_t  upd;
  logic [3:0]  p;
  atr_status_e st;

  always_comb begin
    upd = state_i;
    p   = state_i.pending;
    unique case (state_i.phase)
      PH_TS: begin
        if (data_byte_i == TS_DIRECT || data_byte_i == TS_INVERSE) begin
          upd.phase = PH_T0;
        end else begin
          upd.bad_ts = 1'b1;
          upd.phase  = PH_SKIP;
        end
      end
      PH_T0: begin
        upd.pending = data_byte_i[7:4];
        upd.phase   = (data_byte_i[7:4] != 4'h0) ? PH_IF : PH_SKIP;
      end
      PH_IF: begin
        if (p[PB_TA]) begin
          p = p & 4'hE;
        end else if (p[PB_TB]) begin
          p = p & 4'hC;
        end else if (p[PB_TC]) begin
          p = p & 4'h8;
        end else begin
          // TD opens the next group through its high nibble.
          upd.td_proto = data_byte_i[3:0];
          p            = data_byte_i[7:4];
        end
        upd.pending = p;
        if (p == 4'h0) begin
          upd.phase = PH_SKIP;
        end
        // A TB after a protocol 15 TD with both marker bits ends the parse.
        if (!p[PB_TA] && state_i.pending[PB_TB] && !state_i.pending[PB_TA] &&
            state_i.td_proto == PROTO_T15 && data_byte_i[7] && data_byte_i[1]) begin
          upd.euicc   = 1'b1;
          upd.pending = 4'h0;
          upd.phase   = PH_SKIP;
        end
      end
      PH_SKIP: begin
        upd = state_i;
      end
      default: begin
        upd = state_i;
      end
    endcase

    if (upd.bad_ts) begin
      st = ST_BAD_TS;
    end else if (upd.phase == PH_T0 || upd.phase == PH_IF) begin
      st = ST_TRUNC;
    end else begin
      st = ST_OK;
    end
    result_o.status = st;
    result_o.euicc  = upd.bad_ts ? 1'b0 : upd.euicc;

    // The last byte rearms the parser for the next ATR.
    state_o = last_byte_i ? ATR_STATE_RST : upd;
  end

endmodule

// ----- design/atr_interface_byte_parser_top.sv -----
// Top level of the ATR interface byte parser.
// A result reaches out_o from the result register, which loads when its last byte leaves the input register.
// Throughput: one byte per cycle; a byte is taken every cycle unless a finished
// result waits in the output register while the input register holds a last byte.
// Reset (rst_ni low, asynchronous) empties both registers and rearms the parser to
// expect a convention byte with no flag set.
module atr_interface_byte_parser_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  atr_in_if.sink          in_i,
  atr_out_if.source       out_o
);
  import atr_pkg::*;

  // The input register holds one accepted byte until the parser state absorbs it.
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;

  // Parser state between bytes of one ATR.
  atr_state_t  state_q;
  atr_state_t  state_d;

  // Result register that faces the output channel.
  logic        out_valid_q;
  logic        out_valid_d;
  atr_result_t out_res_q;

  atr_result_t step_res;
  logic        s1_go;
  logic        out_free;

  atr_step u_step (
    .state_i     (state_q),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .state_o     (state_d),
    .result_o    (step_res)
  );

  // The output slot is free when empty or drained in this cycle.
  assign out_free = !out_valid_q || out_o.ready;

  // A byte that is not last produces no transaction and never waits for the output.
  assign s1_go = s1_valid_q && (!s1_last_q || out_free);

  // The input register takes a new byte whenever it is empty or being emptied.
  assign in_i.ready = !s1_valid_q || s1_go;

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (s1_go && s1_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= ATR_STATE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_go) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
    if (s1_go && s1_last_q) begin
      out_res_q <= step_res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_res_q.status;
  assign out_o.euicc_available = out_res_q.euicc;

endmodule

// ----- design/atr_checker.sv -----
// Port-level checker for the ATR parser, bound to its top level.
`include "atr_interface_byte_parser_top_defines.svh"

module atr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic       euicc_i
);
  import atr_pkg::*;

  // A stalled result keeps its fields until it is taken.
  `ATR_ASSERT_RST(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(status_i) && $stable(euicc_i)), "result changed while stalled")

  // A bad convention byte never reports the eUICC flag.
  `ATR_ASSERT_RST(a_bad_ts_no_flag, clk_i, rst_ni, (out_valid_i && status_i == ST_BAD_TS) |-> !euicc_i, "flag set with bad convention byte")

  // With the output slot free the input side always takes a byte.
  `ATR_ASSERT_RST(a_in_ready, clk_i, rst_ni, (!out_valid_i || out_ready_i) |-> in_ready_i, "input stalled with free output slot")

  // No result is offered while reset is held.
  `ATR_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> (!rst_ni ? !out_valid_i : 1'b1), "result offered during reset")

endmodule

bind atr_interface_byte_parser_top atr_checker u_atr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .euicc_i     (out_o.euicc_available)
);
